// ===== design/rgd_pkg.sv =====
// shared types and constants for the radial gradient disc pixel core
package rgd_pkg;

    // geometry limits
    localparam int MAX_DIM      = 256;
    localparam int DIM_W        = 9;
    localparam int COORD_W      = 8;
    localparam int CH_W         = 8;
    localparam int NUM_CH       = 3;

    // datapath widths
    localparam int OFS_W        = 11;
    localparam int ABS_W        = 9;
    localparam int SQ_W         = 18;
    localparam int DSUM_W       = 19;
    localparam int D_W          = 17;
    localparam int M2_W         = 17;
    localparam int PEAK2_W      = 16;
    localparam int PROD_W       = 33;
    localparam int RHS_W        = 32;
    localparam int Q_W          = 24;

    // pipeline depths
    localparam int FRONT_STAGES = 4;
    localparam int NUM_STEPS    = 8;

    // result codes
    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [CH_W-1:0] ALPHA_CLEAR  = 8'd0;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPRITE_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_PEAK      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_PEAK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_PEAK     = 3'd4;

    // channel slots
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // input request
    typedef struct packed {
        logic [COORD_W-1:0] pixel_col;
        logic [COORD_W-1:0] pixel_row;
    } t_in_req;

    // output request
    typedef struct packed {
        logic [CH_W-1:0] alpha_out;
        logic [CH_W-1:0] red_out;
        logic [CH_W-1:0] green_out;
        logic [CH_W-1:0] blue_out;
    } t_out_req;

    // live configuration
    typedef struct packed {
        logic [DIM_W-1:0]             sprite_width;
        logic [DIM_W-1:0]             sprite_height;
        logic [NUM_CH-1:0][CH_W-1:0]  peak;
    } t_cfg;

    // front end to search hand-off
    typedef struct packed {
        logic                          in_disc;
        logic [M2_W-1:0]               m2;
        logic [NUM_CH-1:0][RHS_W-1:0]  rhs;
    } t_front;

endpackage

// ===== design/rgd_front.sv =====
// geometry front end: offsets, squared distance, disc test and per-channel bound
module rgd_front import rgd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_in_req i_req,
    input  t_cfg    i_cfg,
    output logic    o_valid,
    input  logic    i_stall,
    output t_front  o_front
);

    logic [FRONT_STAGES-1:0] r_vld;
    logic [FRONT_STAGES-1:0] n_vld;
    logic [FRONT_STAGES:0]   w_en;

    logic [DIM_W-1:0]  w_w;
    logic [DIM_W-1:0]  w_h;
    logic [DIM_W-1:0]  w_m;
    logic [OFS_W-1:0]  w_dx;
    logic [OFS_W-1:0]  w_dy;
    logic [OFS_W-1:0]  w_adx;
    logic [OFS_W-1:0]  w_ady;

    logic [ABS_W-1:0]  r1_adx;
    logic [ABS_W-1:0]  r1_ady;
    logic [DIM_W-1:0]  r1_m;

    logic [SQ_W-1:0]   w_dx2;
    logic [SQ_W-1:0]   w_dy2;
    logic [SQ_W-1:0]   w_m2;
    logic [SQ_W-1:0]   r2_dx2;
    logic [SQ_W-1:0]   r2_dy2;
    logic [M2_W-1:0]   r2_m2;

    logic [DSUM_W-1:0] w_d;
    logic              w_inside;
    logic [D_W-1:0]    r3_d;
    logic [M2_W-1:0]   r3_m2;
    logic              r3_inside;
    logic [PEAK2_W-1:0] r3_p2 [NUM_CH];

    logic [PROD_W-1:0] w_rhs [NUM_CH];
    logic [RHS_W-1:0]  r4_rhs [NUM_CH];
    logic [M2_W-1:0]   r4_m2;
    logic              r4_inside;

    // stage enables: a stage loads when empty or when its successor moves
    always_comb begin
        w_en[FRONT_STAGES] = !i_stall;
        for (int i = FRONT_STAGES - 1; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign n_vld   = {r_vld[FRONT_STAGES-2:0], i_valid};
    assign o_stall = !w_en[0];
    assign o_valid = r_vld[FRONT_STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < FRONT_STAGES; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= n_vld[i];
                end
            end
        end
    end

    // stage 1: clamp dimensions, doubled offsets from the centre
    always_comb begin
        w_w   = (i_cfg.sprite_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.sprite_width;
        w_h   = (i_cfg.sprite_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : i_cfg.sprite_height;
        w_m   = (w_w < w_h) ? w_w : w_h;
        w_dx  = {2'b00, i_req.pixel_col, 1'b0} - {2'b00, w_w};
        w_dy  = {2'b00, i_req.pixel_row, 1'b0} - {2'b00, w_h};
        w_adx = w_dx[OFS_W-1] ? (OFS_W'(0) - w_dx) : w_dx;
        w_ady = w_dy[OFS_W-1] ? (OFS_W'(0) - w_dy) : w_dy;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r1_adx <= w_adx[ABS_W-1:0];
            r1_ady <= w_ady[ABS_W-1:0];
            r1_m   <= w_m;
        end
    end

    // stage 2: squares
    assign w_dx2 = {9'b0, r1_adx} * {9'b0, r1_adx};
    assign w_dy2 = {9'b0, r1_ady} * {9'b0, r1_ady};
    assign w_m2  = {9'b0, r1_m} * {9'b0, r1_m};

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r2_dx2 <= w_dx2;
            r2_dy2 <= w_dy2;
            r2_m2  <= w_m2[M2_W-1:0];
        end
    end

    // stage 3: squared distance, disc test, squared peaks
    assign w_d      = {1'b0, r2_dx2} + {1'b0, r2_dy2};
    assign w_inside = (r2_m2 != '0) && (w_d <= {2'b00, r2_m2});

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r3_d      <= w_inside ? w_d[D_W-1:0] : '0;
            r3_m2     <= r2_m2;
            r3_inside <= w_inside;
            for (int c = 0; c < NUM_CH; c++) begin
                r3_p2[c] <= {8'b0, i_cfg.peak[c]} * {8'b0, i_cfg.peak[c]};
            end
        end
    end

    // stage 4: bound peak^2 * d per channel
    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            w_rhs[c] = {17'b0, r3_p2[c]} * {16'b0, r3_d};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r4_m2     <= r3_m2;
            r4_inside <= r3_inside;
            for (int c = 0; c < NUM_CH; c++) begin
                r4_rhs[c] <= w_rhs[c][RHS_W-1:0];
            end
        end
    end

    always_comb begin
        o_front.in_disc = r4_inside;
        o_front.m2      = r4_m2;
        for (int c = 0; c < NUM_CH; c++) begin
            o_front.rhs[c] = r4_rhs[c];
        end
    end

endmodule

// ===== design/rgd_search.sv =====
// bit-serial search for each channel level, one result bit per pipeline stage
module rgd_search import rgd_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_front   i_front,
    output logic     o_valid,
    input  logic     i_stall,
    output t_out_req o_req
);

    logic [NUM_STEPS-1:0] r_vld;
    logic [NUM_STEPS-1:0] n_vld;
    logic [NUM_STEPS:0]   w_en;

    // per stage registers: running (k*m)^2, k*m^2, k and the bound
    logic [RHS_W-1:0] r_s   [NUM_STEPS][NUM_CH];
    logic [Q_W-1:0]   r_q   [NUM_STEPS][NUM_CH];
    logic [CH_W-1:0]  r_k   [NUM_STEPS][NUM_CH];
    logic [RHS_W-1:0] r_rhs [NUM_STEPS][NUM_CH];
    logic [M2_W-1:0]  r_m2     [NUM_STEPS];
    logic             r_inside [NUM_STEPS];

    logic [RHS_W-1:0] w_in_s   [NUM_STEPS][NUM_CH];
    logic [Q_W-1:0]   w_in_q   [NUM_STEPS][NUM_CH];
    logic [CH_W-1:0]  w_in_k   [NUM_STEPS][NUM_CH];
    logic [RHS_W-1:0] w_in_rhs [NUM_STEPS][NUM_CH];
    logic [M2_W-1:0]  w_in_m2     [NUM_STEPS];
    logic             w_in_inside [NUM_STEPS];

    logic [RHS_W-1:0] w_cand [NUM_STEPS][NUM_CH];
    logic             w_take [NUM_STEPS][NUM_CH];
    logic [RHS_W-1:0] n_s    [NUM_STEPS][NUM_CH];
    logic [Q_W-1:0]   n_q    [NUM_STEPS][NUM_CH];
    logic [CH_W-1:0]  n_k    [NUM_STEPS][NUM_CH];

    // stage enables
    always_comb begin
        w_en[NUM_STEPS] = !i_stall;
        for (int i = NUM_STEPS - 1; i >= 0; i--) begin
            w_en[i] = !r_vld[i] || w_en[i+1];
        end
    end

    assign n_vld   = {r_vld[NUM_STEPS-2:0], i_valid};
    assign o_stall = !w_en[0];
    assign o_valid = r_vld[NUM_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int i = 0; i < NUM_STEPS; i++) begin
                if (w_en[i]) begin
                    r_vld[i] <= n_vld[i];
                end
            end
        end
    end

    // stage inputs: the first from the front end, the rest from the previous stage
    always_comb begin
        w_in_m2[0]     = i_front.m2;
        w_in_inside[0] = i_front.in_disc;
        for (int c = 0; c < NUM_CH; c++) begin
            w_in_s[0][c]   = '0;
            w_in_q[0][c]   = '0;
            w_in_k[0][c]   = '0;
            w_in_rhs[0][c] = i_front.rhs[c];
        end
        for (int j = 1; j < NUM_STEPS; j++) begin
            w_in_m2[j]     = r_m2[j-1];
            w_in_inside[j] = r_inside[j-1];
            for (int c = 0; c < NUM_CH; c++) begin
                w_in_s[j][c]   = r_s[j-1][c];
                w_in_q[j][c]   = r_q[j-1][c];
                w_in_k[j][c]   = r_k[j-1][c];
                w_in_rhs[j][c] = r_rhs[j-1][c];
            end
        end
    end

    // try bit b: ((k+b)m)^2 = (km)^2 + 2b*k*m^2 + b^2*m^2, all shifts and adds
    always_comb begin
        for (int j = 0; j < NUM_STEPS; j++) begin
            for (int c = 0; c < NUM_CH; c++) begin
                w_cand[j][c] = w_in_s[j][c]
                             + (RHS_W'(w_in_q[j][c]) << (NUM_STEPS - j))
                             + (RHS_W'(w_in_m2[j]) << (2 * (NUM_STEPS - 1 - j)));
                w_take[j][c] = (w_cand[j][c] <= w_in_rhs[j][c]);
                n_s[j][c]    = w_take[j][c] ? w_cand[j][c] : w_in_s[j][c];
                n_q[j][c]    = w_take[j][c]
                             ? (w_in_q[j][c] + (Q_W'(w_in_m2[j]) << (NUM_STEPS - 1 - j)))
                             : w_in_q[j][c];
                n_k[j][c]    = w_take[j][c]
                             ? (w_in_k[j][c] | (CH_W'(1) << (NUM_STEPS - 1 - j)))
                             : w_in_k[j][c];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < NUM_STEPS; j++) begin
            if (w_en[j]) begin
                r_m2[j]     <= w_in_m2[j];
                r_inside[j] <= w_in_inside[j];
                for (int c = 0; c < NUM_CH; c++) begin
                    r_s[j][c]   <= n_s[j][c];
                    r_q[j][c]   <= n_q[j][c];
                    r_k[j][c]   <= n_k[j][c];
                    r_rhs[j][c] <= w_in_rhs[j][c];
                end
            end
        end
    end

    // result from the last stage, forced clear outside the disc
    always_comb begin
        if (r_inside[NUM_STEPS-1]) begin
            o_req.alpha_out = ALPHA_OPAQUE;
            o_req.red_out   = r_k[NUM_STEPS-1][CH_RED];
            o_req.green_out = r_k[NUM_STEPS-1][CH_GREEN];
            o_req.blue_out  = r_k[NUM_STEPS-1][CH_BLUE];
        end else begin
            o_req.alpha_out = ALPHA_CLEAR;
            o_req.red_out   = '0;
            o_req.green_out = '0;
            o_req.blue_out  = '0;
        end
    end

endmodule

// ===== design/radial_gradient_disc_pixel_core.sv =====
// top level: configuration registers and the two pipeline sections
// an accepted request passes through the 4 geometry stages and then the 8 search stages to its result
// throughput: one pixel per cycle while the output is not stalled; each of the 8 search stages resolves one level bit
// stall is elastic: empty stages keep filling while the output is held
// reset: synchronous active low, empties the pipeline and restores size 32x32, peaks 255
// no clearing pass, requests are taken in the first cycle after reset
module radial_gradient_disc_pixel_core import rgd_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_req              i_in_req,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_req             o_out_req,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    t_cfg   r_cfg;
    t_front w_front;
    logic   w_front_valid;
    logic   w_front_stall;

    // configuration writes, unknown indexes ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sprite_width  <= DIM_W'(32);
            r_cfg.sprite_height <= DIM_W'(32);
            r_cfg.peak[CH_RED]   <= CH_W'(255);
            r_cfg.peak[CH_GREEN] <= CH_W'(255);
            r_cfg.peak[CH_BLUE]  <= CH_W'(255);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_SPRITE_WIDTH:  r_cfg.sprite_width  <= i_cfg_data[DIM_W-1:0];
                CFG_SPRITE_HEIGHT: r_cfg.sprite_height <= i_cfg_data[DIM_W-1:0];
                CFG_RED_PEAK:      r_cfg.peak[CH_RED]   <= i_cfg_data[CH_W-1:0];
                CFG_GREEN_PEAK:    r_cfg.peak[CH_GREEN] <= i_cfg_data[CH_W-1:0];
                CFG_BLUE_PEAK:     r_cfg.peak[CH_BLUE]  <= i_cfg_data[CH_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // geometry section
    rgd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (i_in_req),
        .i_cfg   (r_cfg),
        .o_valid (w_front_valid),
        .i_stall (w_front_stall),
        .o_front (w_front)
    );

    // level search section
    rgd_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_front_valid),
        .o_stall (w_front_stall),
        .i_front (w_front),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_req   (o_out_req)
    );

endmodule
